// ===== src/i2c_bus_master_sequencer_macros.svh =====
// Assertion helpers shared by the sequencer RTL.
`ifndef I2C_BUS_MASTER_SEQUENCER_MACROS_SVH
`define I2C_BUS_MASTER_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// Concurrent check that is ignored while reset is high.
`define I2CMS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2cms assertion failed");
// Concurrent check that also holds across reset.
`define I2CMS_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("i2cms assertion failed");
`else
`define I2CMS_ASSERT(name, clk, rst, prop)
`define I2CMS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== src/i2cms_pkg.sv =====
package i2cms_pkg;

   // Sequence modes, which double as the command codes of the action field.
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_START = 3'd1;
   localparam logic [2:0] MODE_STOP  = 3'd2;
   localparam logic [2:0] MODE_WRITE = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;
   localparam logic [2:0] MODE_CLEAR = 3'd5;

   localparam int HALF_W      = 16;
   localparam int PHASE_W     = 7;
   localparam int INIT_PULSES = 28;

   localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(400);
   localparam logic [PHASE_W-1:0] CLEAR_BASE  = PHASE_W'(3 + 2 * INIT_PULSES);
   localparam logic [PHASE_W-1:0] CLEAR_COUNT = PHASE_W'(6 + 2 * INIT_PULSES);

   // Line levels driven in one phase and whether SDA is sampled there.
   typedef struct packed {
      logic sda;
      logic scl;
      logic sample;
   } phase_lv_type;

   // Number of half-clock phases in each sequence.
   function automatic logic [PHASE_W-1:0] phase_count(input logic [2:0] mode);
      logic [PHASE_W-1:0] n;
      unique case (mode)
         MODE_START: n = PHASE_W'(3);
         MODE_STOP:  n = PHASE_W'(3);
         MODE_WRITE: n = PHASE_W'(20);
         MODE_READ:  n = PHASE_W'(21);
         MODE_CLEAR: n = CLEAR_COUNT;
         default:    n = '0;
      endcase
      return n;
   endfunction

endpackage

// ===== src/i2cms_phase.sv =====
module i2cms_phase
   import i2cms_pkg::*;
(
   input  logic [2:0]         mode,
   input  logic [PHASE_W-1:0] idx,
   input  logic [7:0]         shift_byte,
   input  logic               prior_sda,
   input  logic               prior_scl,
   input  logic               ack_level,
   output phase_lv_type       lv
);

   logic [PHASE_W-1:0] idx_m1;
   logic [PHASE_W-1:0] stop_idx;
   logic [2:0]         bit_sel;

   assign idx_m1   = idx - PHASE_W'(1);
   assign stop_idx = idx - CLEAR_BASE;
   assign bit_sel  = 3'd7 - idx_m1[3:1];

   // Decode the SDA/SCL pair of one phase of one sequence.
   always_comb begin
      lv.sda    = 1'b1;
      lv.scl    = 1'b1;
      lv.sample = 1'b0;
      unique case (mode)
         MODE_START: begin
            if (idx == PHASE_W'(0)) begin
               lv.scl = prior_scl;
            end else if (idx == PHASE_W'(2)) begin
               lv.sda = 1'b0;
            end
         end
         MODE_STOP: begin
            if (idx == PHASE_W'(0)) begin
               lv.sda = 1'b0;
               lv.scl = prior_scl;
            end else if (idx == PHASE_W'(1)) begin
               lv.sda = 1'b0;
            end
         end
         MODE_WRITE: begin
            if (idx == PHASE_W'(0)) begin
               lv.sda = prior_sda;
               lv.scl = 1'b0;
            end else if (idx <= PHASE_W'(16)) begin
               lv.sda = shift_byte[bit_sel];
               lv.scl = idx_m1[0];
            end else if (idx == PHASE_W'(18)) begin
               lv.sample = 1'b1;
            end else begin
               lv.scl = 1'b0;
            end
         end
         MODE_READ: begin
            if (idx == PHASE_W'(0)) begin
               lv.sda = prior_sda;
               lv.scl = 1'b0;
            end else if (idx == PHASE_W'(1)) begin
               lv.scl = 1'b0;
            end else if (idx <= PHASE_W'(17)) begin
               // Even phases release SCL and sample a data bit.
               if (!idx[0]) begin
                  lv.sample = 1'b1;
               end else begin
                  lv.scl = 1'b0;
               end
            end else if (idx == PHASE_W'(18)) begin
               lv.sda = ack_level;
               lv.scl = 1'b0;
            end else if (idx == PHASE_W'(19)) begin
               lv.sda = ack_level;
            end else begin
               lv.scl = 1'b0;
            end
         end
         MODE_CLEAR: begin
            if (idx == PHASE_W'(0) || idx == PHASE_W'(2)) begin
               lv.scl = 1'b0;
            end else if (idx == PHASE_W'(1)) begin
               lv.sda = 1'b0;
               lv.scl = 1'b0;
            end else if (idx < CLEAR_BASE) begin
               lv.scl = ~idx[0];
            end else if (stop_idx == PHASE_W'(0)) begin
               lv.sda = 1'b0;
               lv.scl = prior_scl;
            end else if (stop_idx == PHASE_W'(1)) begin
               lv.sda = 1'b0;
            end
         end
         default: begin
            lv.sda = 1'b1;
         end
      endcase
   end

endmodule

// ===== src/i2c_bus_master_sequencer.sv =====
// A word accepted into the input register passes through the step into the result register.
// Throughput: one tick word per cycle; the whole step sits between the input
// register and the result register, and a result stall stalls the input side.
// Reset (synchronous, active high): idle sequence, both lines released,
// half period 400, empty input and result registers.
`include "i2c_bus_master_sequencer_macros.svh"

module i2c_bus_master_sequencer
   import i2cms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Tick word channel.
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_action,
   input  logic [7:0]        req_wr_data,
   input  logic              req_send_ack,
   input  logic              req_sda_in,
   input  logic              req_scl_in,
   // Result word channel.
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_scl_release,
   output logic              rsp_sda_release,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_ack_received,
   output logic              rsp_bus_fault,
   output logic              rsp_cmd_rejected,
   // Half period register write.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [HALF_W-1:0] csr_half_period_ticks
);

   // Input register.
   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        act_ff;
   logic [7:0]        wr_ff;
   logic              sack_ff, sda_ff, scl_ff;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              o_scl_ff, o_sda_ff, o_busy_ff, o_done_ff;
   logic              o_ack_ff, o_fault_ff, o_rej_ff;
   logic [7:0]        o_rd_ff;

   // Sequencer state.
   logic [HALF_W-1:0]  half_ff, half_in;
   logic [2:0]         mode_ff, mode_in;
   logic [PHASE_W-1:0] idx_ff, idx_in;
   logic [HALF_W-1:0]  hold_ff, hold_in;
   logic               stretch_ff, stretch_in;
   logic [7:0]         shift_ff, shift_in;
   logic               drv_sda_ff, drv_sda_in;
   logic               drv_scl_ff, drv_scl_in;
   logic               ackl_ff, ackl_in;
   logic [7:0]         rdres_ff, rdres_in;
   logic               ackf_ff, ackf_in;
   logic               fault_ff, fault_in;

   logic               req_accept, load;
   logic               is_cmd, done_nx, rej_nx, do_enter;
   logic [HALF_W-1:0]  hold_len, hold_cur, hold_dec, hold_mid;
   logic               stretch_mid;
   logic [PHASE_W-1:0] idx_inc;
   phase_lv_type       cur_lv, ent_lv;

   // Handshakes: the step runs when the result register is free or draining.
   assign load        = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !load;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept ? 1'b1 : (load ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign csr_ready   = 1'b1;
   assign half_in     = (csr_valid && csr_ready) ? csr_half_period_ticks : half_ff;

   assign is_cmd   = (act_ff >= MODE_START) && (act_ff <= MODE_CLEAR);
   assign hold_len = (half_ff == '0) ? HALF_W'(1) : half_ff;
   assign idx_inc  = idx_ff + PHASE_W'(1);

   // Levels of the current phase, used for the sample at the SCL high edge.
   i2cms_phase u_cur (
      .mode       (mode_ff),
      .idx        (idx_ff),
      .shift_byte (shift_ff),
      .prior_sda  (drv_sda_ff),
      .prior_scl  (drv_scl_ff),
      .ack_level  (ackl_ff),
      .lv         (cur_lv)
   );

   // Levels of the phase being entered this tick.
   i2cms_phase u_ent (
      .mode       (mode_in),
      .idx        (idx_in),
      .shift_byte (shift_in),
      .prior_sda  (drv_sda_ff),
      .prior_scl  (drv_scl_ff),
      .ack_level  (ackl_in),
      .lv         (ent_lv)
   );

   // Command start, stretch wait, hold countdown and phase advance.
   always_comb begin
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      shift_in    = shift_ff;
      ackl_in     = ackl_ff;
      rdres_in    = rdres_ff;
      ackf_in     = ackf_ff;
      fault_in    = fault_ff;
      hold_mid    = hold_ff;
      stretch_mid = stretch_ff;
      hold_cur    = hold_ff;
      hold_dec    = '0;
      done_nx     = 1'b0;
      rej_nx      = 1'b0;
      do_enter    = 1'b0;
      if (mode_ff == MODE_IDLE) begin
         if (is_cmd) begin
            do_enter = 1'b1;
            if (act_ff == MODE_WRITE) begin
               shift_in = wr_ff;
            end
            if (act_ff == MODE_READ) begin
               shift_in = '0;
               ackl_in  = ~sack_ff;
            end
            if (act_ff == MODE_CLEAR) begin
               fault_in = ~scl_ff;
               if (!scl_ff) begin
                  done_nx  = 1'b1;
                  do_enter = 1'b0;
               end
            end
            if (do_enter) begin
               mode_in = act_ff;
               idx_in  = '0;
            end
         end
      end else begin
         rej_nx = is_cmd;
         if (!stretch_ff || scl_ff) begin
            // SCL reads high: sample if this phase asks for it, then hold.
            if (stretch_ff) begin
               if (cur_lv.sample && mode_ff == MODE_WRITE) begin
                  ackf_in = ~sda_ff;
               end
               if (cur_lv.sample && mode_ff == MODE_READ) begin
                  shift_in = {shift_ff[6:0], sda_ff};
               end
               stretch_mid = 1'b0;
               hold_cur    = hold_len;
            end
            hold_dec = (hold_cur != '0) ? hold_cur - HALF_W'(1) : '0;
            hold_mid = hold_dec;
            if (hold_dec == '0) begin
               if (idx_inc >= phase_count(mode_ff)) begin
                  if (mode_ff == MODE_READ) begin
                     rdres_in = shift_in;
                  end
                  if (mode_ff == MODE_CLEAR && !sda_ff) begin
                     fault_in = 1'b1;
                  end
                  mode_in     = MODE_IDLE;
                  idx_in      = '0;
                  stretch_mid = 1'b0;
                  done_nx     = 1'b1;
               end else begin
                  idx_in   = idx_inc;
                  do_enter = 1'b1;
               end
            end
         end
      end
   end

   // Entering a phase drives its levels and arms the stretch wait or the hold.
   always_comb begin
      drv_sda_in = drv_sda_ff;
      drv_scl_in = drv_scl_ff;
      stretch_in = stretch_mid;
      hold_in    = hold_mid;
      if (do_enter) begin
         drv_sda_in = ent_lv.sda;
         drv_scl_in = ent_lv.scl;
         stretch_in = ent_lv.scl;
         hold_in    = ent_lv.scl ? '0 : hold_len;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         half_ff      <= HALF_RESET;
         mode_ff      <= MODE_IDLE;
         idx_ff       <= '0;
         hold_ff      <= '0;
         stretch_ff   <= 1'b0;
         shift_ff     <= '0;
         drv_sda_ff   <= 1'b1;
         drv_scl_ff   <= 1'b1;
         ackl_ff      <= 1'b1;
         rdres_ff     <= '0;
         ackf_ff      <= 1'b0;
         fault_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
         if (load) begin
            mode_ff    <= mode_in;
            idx_ff     <= idx_in;
            hold_ff    <= hold_in;
            stretch_ff <= stretch_in;
            shift_ff   <= shift_in;
            drv_sda_ff <= drv_sda_in;
            drv_scl_ff <= drv_scl_in;
            ackl_ff    <= ackl_in;
            rdres_ff   <= rdres_in;
            ackf_ff    <= ackf_in;
            fault_ff   <= fault_in;
         end
      end
   end

   // Payload registers of the input and result stages.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff  <= req_action;
         wr_ff   <= req_wr_data;
         sack_ff <= req_send_ack;
         sda_ff  <= req_sda_in;
         scl_ff  <= req_scl_in;
      end
      if (load) begin
         o_scl_ff   <= drv_scl_in;
         o_sda_ff   <= drv_sda_in;
         o_busy_ff  <= (mode_in != MODE_IDLE);
         o_done_ff  <= done_nx;
         o_rd_ff    <= rdres_in;
         o_ack_ff   <= ackf_in;
         o_fault_ff <= fault_in;
         o_rej_ff   <= rej_nx;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_release  = o_scl_ff;
   assign rsp_sda_release  = o_sda_ff;
   assign rsp_busy_res     = o_busy_ff;
   assign rsp_done_res     = o_done_ff;
   assign rsp_read_byte    = o_rd_ff;
   assign rsp_ack_received = o_ack_ff;
   assign rsp_bus_fault    = o_fault_ff;
   assign rsp_cmd_rejected = o_rej_ff;

   // An idle sequencer has no phase in flight.
   `I2CMS_ASSERT(a_idle_clean, clock, reset,
      (mode_ff == MODE_IDLE) |-> (!stretch_ff && idx_ff == '0))
   // While the stretch wait is armed, the hold count stays at zero.
   `I2CMS_ASSERT(a_stretch_no_hold, clock, reset, stretch_ff |-> (hold_ff == '0))
   // The phase index stays inside the running sequence.
   `I2CMS_ASSERT(a_idx_range, clock, reset,
      (mode_ff != MODE_IDLE) |-> (idx_ff < phase_count(mode_ff)))
   // A finishing step leaves the sequencer idle.
   `I2CMS_ASSERT(a_done_idle, clock, reset, (load && done_nx) |=> (mode_ff == MODE_IDLE))
   // The input side only stalls while a word waits in the input register.
   `I2CMS_ASSERT_ALWAYS(a_stall_held, clock, req_stall |-> s1_valid_ff)

endmodule
